// ===== rtl/wjmc_pkg.sv =====
`default_nettype none

package wjmc_pkg;

    localparam int MAX_JUMP_DEF = 128;
    localparam int HEIGHT_W     = 16;
    localparam int COST_W       = 32;
    localparam int LIMIT_W      = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd2;
    localparam logic [COST_W-1:0]  COST_MAX  = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/window_jump_min_cost.sv =====
// Least-cost path over a stream of node heights. Each accepted word carries one
// node's height; the block returns that node's least cost (zero for the first
// node of a sequence, else the minimum over the last jump_limit nodes of their
// cost plus the absolute height difference, saturating at all ones). The last
// flag ends a sequence and empties the window. The window lives in one memory
// of MAX_JUMP entries that is read one entry per cycle into a single shared
// add and compare unit, and a new node is accepted only when the previous one
// has left the search. The search covers span entries, where span is the
// smaller of the nodes held and jump_limit (clamped to MAX_JUMP). With nothing
// to search (an empty window or a zero jump_limit) the search state is skipped.
// The finished word sits in an output register, so a new node is taken while it
// waits. No clearing pass.
`default_nettype none

module window_jump_min_cost #(
    parameter int MAX_JUMP = wjmc_pkg::MAX_JUMP_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [wjmc_pkg::LIMIT_W-1:0]  i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [wjmc_pkg::HEIGHT_W-1:0] i_height,
    input  wire logic                          i_last,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [wjmc_pkg::COST_W-1:0]        o_cost,
    output logic                               o_done_res
);

    localparam int AW = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
    localparam int FW = $clog2(MAX_JUMP + 1);
    localparam int LW = (FW > wjmc_pkg::LIMIT_W) ? FW : wjmc_pkg::LIMIT_W;
    localparam int HW = wjmc_pkg::HEIGHT_W;
    localparam int CW = wjmc_pkg::COST_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_JUMP - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(MAX_JUMP);
    localparam logic [LW-1:0] LIM_MAX   = LW'(MAX_JUMP);

    wjmc_pkg::t_state r_state, n_state;

    logic [wjmc_pkg::LIMIT_W-1:0] r_limit;
    logic [FW-1:0]                r_fill, n_fill;
    logic [AW-1:0]                r_head, n_head;
    logic [AW-1:0]                r_addr, n_addr;
    logic [FW-1:0]                r_left, n_left;
    logic                         r_rvld, n_rvld;
    logic [HW-1:0]                r_h, n_h;
    logic                         r_last, n_last;
    logic [CW-1:0]                r_best, n_best;
    logic                         r_ovalid, n_ovalid;
    logic [CW-1:0]                r_ocost, n_ocost;
    logic                         r_odone, n_odone;

    logic [HW+CW-1:0] r_mem [MAX_JUMP];
    logic [HW+CW-1:0] r_rd;

    logic             in_acc;
    logic             out_free;
    logic             wr_en;
    logic [LW-1:0]    lim_ext;
    logic [LW-1:0]    fill_ext;
    logic [FW-1:0]    span;
    logic [AW-1:0]    head_prev;
    logic [AW-1:0]    addr_prev;
    logic [HW-1:0]    rd_h;
    logic [CW-1:0]    rd_c;
    logic [HW-1:0]    diff;
    logic [CW:0]      sum;
    logic [CW-1:0]    cand;

    assign o_ready    = (r_state == wjmc_pkg::S_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign out_free   = !r_ovalid || i_ready;
    assign o_valid    = r_ovalid;
    assign o_cost     = r_ocost;
    assign o_done_res = r_odone;

    // window span: min(fill, limit, MAX_JUMP)
    always_comb begin
        lim_ext  = LW'(r_limit);
        fill_ext = LW'(r_fill);
        if (lim_ext > LIM_MAX) begin
            lim_ext = LIM_MAX;
        end
        span = (fill_ext < lim_ext) ? r_fill : FW'(lim_ext);
    end

    assign head_prev = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);
    assign addr_prev = (r_addr == '0) ? LAST_SLOT : r_addr - AW'(1);

    // shared saturating add and compare
    assign rd_h = r_rd[HW+CW-1:CW];
    assign rd_c = r_rd[CW-1:0];
    assign diff = (rd_h > r_h) ? (rd_h - r_h) : (r_h - rd_h);
    assign sum  = {1'b0, rd_c} + {{(CW+1-HW){1'b0}}, diff};
    assign cand = sum[CW] ? wjmc_pkg::COST_MAX : sum[CW-1:0];

    assign wr_en = (r_state == wjmc_pkg::S_DONE) && out_free && !r_last;

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_head   = r_head;
        n_addr   = r_addr;
        n_left   = r_left;
        n_rvld   = 1'b0;
        n_h      = r_h;
        n_last   = r_last;
        n_best   = r_best;
        n_ovalid = r_ovalid && !i_ready;
        n_ocost  = r_ocost;
        n_odone  = r_odone;
        unique case (r_state)
            wjmc_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_h    = i_height;
                    n_last = i_last;
                    n_addr = head_prev;
                    n_left = span;
                    if (r_fill == '0) begin
                        n_best  = '0;
                        n_state = wjmc_pkg::S_DONE;
                    end else if (span == '0) begin
                        n_best  = wjmc_pkg::COST_MAX;
                        n_state = wjmc_pkg::S_DONE;
                    end else begin
                        n_best  = wjmc_pkg::COST_MAX;
                        n_state = wjmc_pkg::S_RUN;
                    end
                end
            end
            wjmc_pkg::S_RUN: begin
                if (r_left != '0) begin
                    n_rvld = 1'b1;
                    n_left = r_left - FW'(1);
                    n_addr = addr_prev;
                end
                if (r_rvld) begin
                    if (cand < r_best) begin
                        n_best = cand;
                    end
                    if (r_left == '0) begin
                        n_state = wjmc_pkg::S_DONE;
                    end
                end
            end
            wjmc_pkg::S_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocost  = r_best;
                    n_odone  = r_last;
                    n_state  = wjmc_pkg::S_IDLE;
                    if (r_last) begin
                        n_head = '0;
                        n_fill = '0;
                    end else begin
                        n_head = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                        if (r_fill != FILL_MAX) begin
                            n_fill = r_fill + FW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = wjmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wjmc_pkg::S_IDLE;
            r_limit  <= wjmc_pkg::LIMIT_RST;
            r_fill   <= '0;
            r_head   <= '0;
            r_left   <= '0;
            r_rvld   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_head   <= n_head;
            r_left   <= n_left;
            r_rvld   <= n_rvld;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_h     <= n_h;
        r_last  <= n_last;
        r_best  <= n_best;
        r_ocost <= n_ocost;
        r_odone <= n_odone;
    end

    // window memory: height and cost per entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_head] <= {r_h, r_best};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("window fill above depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_SLOT)
        else $error("window head out of range");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_fill == '0) |=> (r_state == wjmc_pkg::S_DONE && r_best == '0))
        else $error("first node of a sequence must cost zero");

    a_write_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_fill != '0))
        else $error("window empty after a write");

    a_run_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wjmc_pkg::S_RUN && r_left == '0) |-> r_rvld)
        else $error("search stalled with no read in flight");

endmodule

`default_nettype wire

// ===== tb/window_jump_min_cost_tb.sv =====
`timescale 1ns / 100ps

module window_jump_min_cost_tb;

    localparam int WIN_DEPTH   = 128;
    localparam int NODE_TARGET = 1150;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic [wjmc_pkg::HEIGHT_W-1:0] height;
        logic                          last;
    } t_node;

    typedef struct packed {
        logic [wjmc_pkg::COST_W-1:0] cost;
        logic                        done_res;
    } t_path_cost;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic [wjmc_pkg::LIMIT_W-1:0]  i_cfg_wr_data = '0;
    logic                          i_valid       = 1'b0;
    logic [wjmc_pkg::HEIGHT_W-1:0] i_height      = '0;
    logic                          i_last        = 1'b0;
    logic                          i_ready       = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic [wjmc_pkg::COST_W-1:0]   o_cost;
    logic                          o_done_res;

    t_node      pending_nodes [$];
    t_path_cost min_cost_q    [$];

    // window copy for cost prediction
    logic [wjmc_pkg::HEIGHT_W-1:0] height_hist [WIN_DEPTH];
    logic [wjmc_pkg::COST_W-1:0]   cost_hist   [WIN_DEPTH];
    int unsigned                   hist_fill = 0;
    logic [6:0]                    hist_head = '0;
    logic [wjmc_pkg::LIMIT_W-1:0]  jump_lim  = wjmc_pkg::LIMIT_RST;

    int  n_queued  = 0;
    int  n_costs   = 0;
    int  n_err     = 0;
    int  cycle_cnt = 0;
    bit  steady    = 1'b0;

    window_jump_min_cost DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_height     (i_height),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cost       (o_cost),
        .o_done_res   (o_done_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** window_jump_min_cost: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    task automatic relax_node(input t_node nd, output t_path_cost res);
        int unsigned                 lim;
        int unsigned                 span;
        logic [6:0]                  idx;
        logic [wjmc_pkg::COST_W-1:0] diff;
        logic [wjmc_pkg::COST_W:0]   sum;
        logic [wjmc_pkg::COST_W-1:0] best;
        lim = (jump_lim > WIN_DEPTH) ? WIN_DEPTH : jump_lim;
        if (hist_fill == 0) begin
            best = '0;
        end else begin
            best = wjmc_pkg::COST_MAX;
            span = (hist_fill < lim) ? hist_fill : lim;
            for (int d = 1; d <= span; d++) begin
                idx  = hist_head - 7'(d);
                diff = (height_hist[idx] > nd.height) ? height_hist[idx] - nd.height
                                                      : nd.height - height_hist[idx];
                sum  = cost_hist[idx] + diff;
                if (sum[wjmc_pkg::COST_W])
                    sum = {1'b0, wjmc_pkg::COST_MAX};
                if (sum[wjmc_pkg::COST_W-1:0] < best)
                    best = sum[wjmc_pkg::COST_W-1:0];
            end
        end
        if (nd.last) begin
            hist_fill = 0;
            hist_head = '0;
        end else begin
            height_hist[hist_head] = nd.height;
            cost_hist[hist_head]   = best;
            hist_head              = hist_head + 7'd1;
            if (hist_fill < WIN_DEPTH)
                hist_fill++;
        end
        res.cost     = best;
        res.done_res = nd.last;
    endtask

    // node driver
    always @(posedge i_clk) begin : drive_nodes
        t_path_cost res;
        int         send_gap;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                relax_node(pending_nodes.pop_front(), res);
                min_cost_q.insert(min_cost_q.size(), res);
            end
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_nodes.size() != 0) begin
                    i_valid  <= 1'b1;
                    i_height <= pending_nodes[0].height;
                    i_last   <= pending_nodes[0].last;
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // cost monitor
    always @(posedge i_clk) begin : check_costs
        t_path_cost want;
        int         recv_gap;
        int         hold_left;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                n_costs++;
                if (min_cost_q.size() == 0) begin
                    $display("%0t: unexpected word, cost %0d done_res %0b",
                             $time, o_cost, o_done_res);
                    n_err++;
                end else begin
                    want = min_cost_q.pop_front();
                    if (o_cost !== want.cost) begin
                        $display("%0t: cost mismatch, expected %0d actual %0d",
                                 $time, want.cost, o_cost);
                        n_err++;
                    end
                    if (o_done_res !== want.done_res) begin
                        $display("%0t: done_res mismatch, expected %0b actual %0b",
                                 $time, want.done_res, o_done_res);
                        n_err++;
                    end
                end
                if (n_costs == 60 || n_costs == 700)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready  <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic queue_node(input logic [wjmc_pkg::HEIGHT_W-1:0] h, input logic last);
        t_node nd;
        nd.height = h;
        nd.last   = last;
        pending_nodes.insert(pending_nodes.size(), nd);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (pending_nodes.size() != 0 || min_cost_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_jump_limit(input logic [wjmc_pkg::LIMIT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        jump_lim = v;
    endtask

    initial begin : stimulus
        int                            phase;
        int                            r;
        int                            n;
        int                            seq_left;
        logic [wjmc_pkg::HEIGHT_W-1:0] h;
        logic [wjmc_pkg::HEIGHT_W-1:0] prev_h;
        logic [wjmc_pkg::LIMIT_W-1:0]  lim;
        phase    = 0;
        seq_left = 0;
        prev_h   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit, height extremes, lone node
        queue_node(16'd0, 1'b0);
        queue_node(16'hFFFF, 1'b0);
        queue_node(16'd0, 1'b0);
        queue_node(16'hFFFF, 1'b1);
        queue_node(16'd1234, 1'b1);
        wait_drained();

        // zero limit leaves later nodes unreachable
        write_jump_limit(8'd0);
        queue_node(16'd100, 1'b0);
        queue_node(16'd200, 1'b0);
        queue_node(16'd300, 1'b0);
        wait_drained();

        // limit raised mid-sequence over unreachable nodes
        write_jump_limit(8'd1);
        queue_node(16'd300, 1'b0);
        queue_node(16'd50, 1'b1);
        wait_drained();

        // limit above window depth
        write_jump_limit(8'd255);
        queue_node(16'd5, 1'b0);
        queue_node(16'hFFFF, 1'b0);
        queue_node(16'd0, 1'b0);
        queue_node(16'd7, 1'b1);
        wait_drained();

        write_jump_limit(8'd128);
        queue_node(16'd0, 1'b0);
        queue_node(16'hFFFF, 1'b0);
        queue_node(16'd1, 1'b1);
        wait_drained();

        while (n_queued < NODE_TARGET) begin
            phase++;
            steady = (phase % 5 == 2);
            r = $urandom_range(0, 99);
            if (phase % 7 == 3) begin
                // long sequence, window wraps
                lim      = (r < 50) ? 8'd128 : 8'($urandom_range(129, 255));
                n        = $urandom_range(140, 180);
                seq_left = n;
            end else begin
                if (r < 55)
                    lim = 8'($urandom_range(1, 8));
                else if (r < 65)
                    lim = 8'd0;
                else if (r < 75)
                    lim = 8'($urandom_range(9, 40));
                else if (r < 85)
                    lim = r[0] ? 8'd128 : 8'd255;
                else
                    lim = 8'($urandom);
                n = $urandom_range(15, 60);
            end
            if (n > NODE_TARGET - n_queued)
                n = NODE_TARGET - n_queued;
            write_jump_limit(lim);
            repeat (n) begin
                if (seq_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        seq_left = $urandom_range(1, 6);
                    else if (r < 95)
                        seq_left = $urandom_range(7, 30);
                    else
                        seq_left = $urandom_range(31, 150);
                end
                r = $urandom_range(0, 99);
                if (r < 10)
                    h = r[0] ? 16'hFFFF : 16'd0;
                else if (r < 55)
                    h = prev_h + 16'($urandom_range(0, 64)) - 16'd32;
                else
                    h = 16'($urandom);
                queue_node(h, seq_left == 1);
                seq_left--;
                prev_h = h;
            end
            wait_drained();
        end

        steady = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (n_err == 0)
            $display("** window_jump_min_cost: PASSED **");
        else
            $display("** window_jump_min_cost: FAILED **");
        $finish;
    end

endmodule
